### rtl/cot_pkg.sv
// Package: shared beat types, register indexes and constants for the clock offset tracker.
package cot_pkg;

   localparam int CsrAddrWidth = 4;
   localparam int CsrDataWidth = 32;
   localparam int WeightWidth  = 17;
   localparam int ThreshWidth  = 30;

   // Register indexes on the configuration channel
   localparam logic [CsrAddrWidth-1:0] RegBlendWeight   = CsrAddrWidth'(0);
   localparam logic [CsrAddrWidth-1:0] RegSnapThreshold = CsrAddrWidth'(1);

   localparam logic [WeightWidth-1:0] WeightOne        = WeightWidth'(65536);
   localparam logic [WeightWidth-1:0] WeightReset      = WeightWidth'(62259);
   localparam logic [ThreshWidth-1:0] ThreshReset      = ThreshWidth'(10000000);

   localparam logic [63:0] Int64Max = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] Int64Min = 64'h8000_0000_0000_0000;

   localparam logic CmdSync    = 1'b0;
   localparam logic CmdConvert = 1'b1;

   typedef struct packed {
      logic        command;
      logic [63:0] remote_stamp;
      logic [63:0] sent_stamp;
      logic [63:0] local_now;
      logic [63:0] remote_time;
   } req_type;

   typedef struct packed {
      logic [63:0] local_time;
      logic        used_fallback;
      logic [63:0] offset_now;
      logic        snapped;
      logic        is_synced;
   } rsp_type;

   // Stage two contents: measurement already formed from the raw stamps
   typedef struct packed {
      logic        command;
      logic        take_meas;
      logic [63:0] meas;
      logic [63:0] local_now;
      logic [63:0] remote_time;
   } stage_type;

endpackage

### rtl/cot_ifs.sv
// Interfaces: request, response and configuration channels of the clock offset tracker.
interface cot_req_if;
   logic             valid;
   logic             ready;
   cot_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface cot_rsp_if;
   logic             valid;
   logic             ready;
   cot_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface cot_csr_if;
   logic                               valid;
   logic                               ready;
   logic [cot_pkg::CsrAddrWidth-1:0]   index;
   logic [cot_pkg::CsrDataWidth-1:0]   wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

### rtl/cot_measure.sv
// Measurement: (sent + now - 2*remote)/2 toward zero, saturated to 64 bits.
module cot_measure (
   input  cot_pkg::req_type   req,
   output cot_pkg::stage_type stage
);

   logic [65:0] sum_w;
   logic [65:0] adj_w;
   logic [64:0] half_w;
   logic [63:0] meas_w;

   assign sum_w = {{2{req.sent_stamp[63]}}, req.sent_stamp}
                + {{2{req.local_now[63]}}, req.local_now}
                - {req.remote_stamp[63], req.remote_stamp, 1'b0};
   // negative odd values round toward zero
   assign adj_w  = sum_w + {65'b0, sum_w[65]};
   assign half_w = adj_w[65:1];

   always_comb begin
      if (half_w[64] != half_w[63]) begin
         meas_w = half_w[64] ? cot_pkg::Int64Min : cot_pkg::Int64Max;
      end else begin
         meas_w = half_w[63:0];
      end
   end

   assign stage.command     = req.command;
   assign stage.take_meas   = (req.command == cot_pkg::CmdSync) && !req.remote_stamp[63]
                            && (req.remote_stamp != 64'b0);
   assign stage.meas        = meas_w;
   assign stage.local_now   = req.local_now;
   assign stage.remote_time = req.remote_time;

endmodule

### rtl/cot_step.sv
// Step: snap or blend of the stored offset, and remote-to-local conversion.
module cot_step (
   input  cot_pkg::stage_type                 stage,
   input  logic [63:0]                        offset,
   input  logic                               synced,
   input  logic [cot_pkg::WeightWidth-1:0]    weight,
   input  logic [cot_pkg::ThreshWidth-1:0]    thresh,
   output cot_pkg::rsp_type                   rsp
);

   logic [64:0]                     d_w;
   logic [64:0]                     mag_w;
   logic                            snap_w;
   logic [cot_pkg::WeightWidth-1:0] w_eff;
   logic signed [30:0]              d_s;
   logic signed [17:0]              w_s;
   logic signed [48:0]              prod_w;
   logic [80:0]                     sprod_w;
   logic [80:0]                     total_w;
   logic [80:0]                     adj_w;
   logic [63:0]                     blend_w;
   logic [64:0]                     csum_w;
   logic                            fallback_w;

   assign d_w    = {stage.meas[63], stage.meas} - {offset[63], offset};
   assign mag_w  = d_w[64] ? (65'b0 - d_w) : d_w;
   assign snap_w = !synced || (mag_w > {35'b0, thresh});

   assign w_eff   = (weight > cot_pkg::WeightOne) ? cot_pkg::WeightOne : weight;
   // |d| is under 2^30 whenever the blend is used, so d fits 31 bits signed
   assign d_s     = d_w[30:0];
   assign w_s     = {1'b0, w_eff};
   assign prod_w  = d_s * w_s;
   assign sprod_w = {{32{prod_w[48]}}, prod_w};
   assign total_w = {offset[63], offset, 16'b0} + sprod_w;
   assign adj_w   = total_w + (total_w[80] ? 81'h0FFFF : 81'b0);
   // weighted mean of two 64-bit values, no saturation needed
   assign blend_w = adj_w[79:16];

   assign csum_w     = {stage.remote_time[63], stage.remote_time} + {offset[63], offset};
   assign fallback_w = !synced || csum_w[64];

   always_comb begin
      rsp.local_time    = 64'b0;
      rsp.used_fallback = 1'b0;
      rsp.offset_now    = offset;
      rsp.snapped       = 1'b0;
      rsp.is_synced     = synced;
      if (stage.command == cot_pkg::CmdConvert) begin
         rsp.used_fallback = fallback_w;
         if (fallback_w) begin
            rsp.local_time = stage.local_now;
         end else if (csum_w[63]) begin
            rsp.local_time = cot_pkg::Int64Max;
         end else begin
            rsp.local_time = csum_w[63:0];
         end
      end else if (stage.take_meas) begin
         rsp.is_synced = 1'b1;
         rsp.snapped   = snap_w;
         rsp.offset_now = snap_w ? stage.meas : blend_w;
      end
   end

endmodule

### rtl/clock_offset_tracker.sv
// Top level: clock offset tracker with three-register pipeline and config registers.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+-----------------------------------------------
//   req_ch   | in  | valid / ready | command, remote_stamp, sent_stamp, local_now,
//            |     |               | remote_time
//   rsp_ch   | out | valid / ready | local_time, used_fallback, offset_now, snapped,
//            |     |               | is_synced
//   csr_ch   | in  | valid / ready | index, wdata (ready always high)
//
// One beat per cycle sustained while rsp_ch is not stalled; each request beat passes
// the input register, measurement register and result register before its result appears.
// The rate is set by the offset update in the step unit: measurement-to-offset
// compare, one 31x18 signed multiply and the blend add close combinationally on stage two.
// Synchronous active-high reset clears the offset, synced flag, valids and
// restores the register defaults. A stalled rsp_ch back-pressures the stages
// in turn; req_ch.ready drops only when all three registers are full.
module clock_offset_tracker (
   input  logic        clock,
   input  logic        reset,
   cot_req_if.sink     req_ch,
   cot_rsp_if.source   rsp_ch,
   cot_csr_if.sink     csr_ch
);

   // config registers
   logic [cot_pkg::WeightWidth-1:0] weight_ff;
   logic [cot_pkg::ThreshWidth-1:0] thresh_ff;

   // tracking state
   logic [63:0] offset_ff;
   logic        synced_ff;

   // pipeline
   logic               s1_valid_ff;
   cot_pkg::req_type   s1_data_ff;
   logic               s2_valid_ff;
   cot_pkg::stage_type s2_data_ff;
   logic               rsp_valid_ff;
   cot_pkg::rsp_type   rsp_data_ff;

   logic               s1_valid_in;
   logic               s2_valid_in;
   logic               rsp_valid_in;

   cot_pkg::stage_type meas_stage;
   cot_pkg::rsp_type   step_rsp;

   logic out_open;
   logic s2_move;
   logic s1_move;
   logic req_take;

   // stall chain, back from the result register
   assign out_open = !rsp_valid_ff || rsp_ch.ready;
   assign s2_move  = s2_valid_ff && out_open;
   assign s1_move  = s1_valid_ff && (!s2_valid_ff || s2_move);
   assign req_ch.ready = !s1_valid_ff || s1_move;
   assign req_take = req_ch.valid && req_ch.ready;

   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   cot_measure u_measure (
      .req   (s1_data_ff),
      .stage (meas_stage)
   );

   cot_step u_step (
      .stage  (s2_data_ff),
      .offset (offset_ff),
      .synced (synced_ff),
      .weight (weight_ff),
      .thresh (thresh_ff),
      .rsp    (step_rsp)
   );

   always_comb begin
      s1_valid_in  = req_take || (s1_valid_ff && !s1_move);
      s2_valid_in  = s1_move || (s2_valid_ff && !s2_move);
      rsp_valid_in = s2_move || (rsp_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_ch.data;
      end
      if (s1_move) begin
         s2_data_ff <= meas_stage;
      end
      if (s2_move) begin
         rsp_data_ff <= step_rsp;
      end
   end

   // offset state advances as each stage-two beat leaves
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= 64'b0;
         synced_ff <= 1'b0;
      end else if (s2_move) begin
         offset_ff <= step_rsp.offset_now;
         synced_ff <= step_rsp.is_synced;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= cot_pkg::WeightReset;
         thresh_ff <= cot_pkg::ThreshReset;
      end else if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.index)
            cot_pkg::RegBlendWeight: begin
               weight_ff <= csr_ch.wdata[cot_pkg::WeightWidth-1:0];
            end
            cot_pkg::RegSnapThreshold: begin
               thresh_ff <= csr_ch.wdata[cot_pkg::ThreshWidth-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // once synced, only reset clears the flag
   a_synced_sticky: assert property (@(posedge clock) disable iff (reset)
      synced_ff |=> synced_ff)
      else $error("synced flag dropped");

   // a snap always leaves the block synced and is never a fallback
   a_snap_synced: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.snapped) |-> (rsp_data_ff.is_synced
                                                 && !rsp_data_ff.used_fallback))
      else $error("snap result inconsistent");

   // offset stays zero until the first measurement is taken
   a_unsynced_zero: assert property (@(posedge clock) disable iff (reset)
      !synced_ff |-> (offset_ff == 64'b0))
      else $error("offset moved while unsynced");

   // a taken request beat always lands in the input register
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff)
      else $error("request beat lost");

endmodule
